>>> hw/rtl/range_distinct_count_defines.svh
// Assertion macros for the range distinct-count RTL.
`ifndef RANGE_DISTINCT_COUNT_DEFINES_SVH
`define RANGE_DISTINCT_COUNT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RDC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define RDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rdc_pkg.sv
// Package: sizes, codes and helpers for the range distinct-count block.
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

  // Both depths are powers of two, so position and value wrap by truncation.
  localparam int ARRAY_DEPTH = 1024;
  localparam int VALUE_COUNT = 1024;

  localparam int FIELD_W = 10;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  localparam int AW = $clog2(ARRAY_DEPTH);
  localparam int VW = $clog2(VALUE_COUNT);
  // Window pointers carry a sign so the empty window can sit at minus one.
  localparam int PW = AW + 1;
  // Occurrence counts run from minus ARRAY_DEPTH to plus ARRAY_DEPTH.
  localparam int CW = AW + 2;
  localparam int DW = $clog2(VALUE_COUNT + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_EMPTY = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_RANGE = 2'd1,
    STAT_REFUSED   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_STORE_WAIT,
    ST_COUNT_WAIT
  } state_t;

  function automatic logic [AW-1:0] clamp_bound(input logic [FIELD_W-1:0] x);
    if (32'(x) >= ARRAY_DEPTH) begin
      return AW'(ARRAY_DEPTH - 1);
    end
    return AW'(x);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rdc_ram.sv
// Generic single-port RAM with a registered, read-first output.
`timescale 1ns / 1ps
`default_nettype none

module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/range_distinct_count.sv
// Top level: distinct-value counting over a sliding window of a position store.
//
//   channel  | handshake        | payload
//   ---------+------------------+------------------------------------------
//   command  | start, busy      | command, position, value, left, right
//   result   | done (strobe)    | distinct_count, status
//
// A beat is taken at a clock edge with start high and busy low; its result
// shows on done in the cycle after the last of its work.
// Load, refused load, bad range and unknown command: result on the next cycle.
// Query: each pointer step is a store read, a count read and a count write,
// done in turn through the two single-port memories.
// Empty command: result on the next cycle, then busy while the count memory
// is swept to zero. rst (synchronous) starts the same sweep. The receiver
// cannot stall; done lasts one cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "range_distinct_count_defines.svh"

module range_distinct_count
  import rdc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CMD_W-1:0]   command,
  input  wire logic [FIELD_W-1:0] position,
  input  wire logic [FIELD_W-1:0] value,
  input  wire logic [FIELD_W-1:0] left,
  input  wire logic [FIELD_W-1:0] right,
  output logic                    done,
  output logic [DW-1:0]           distinct_count,
  output logic [STAT_W-1:0]       status
);

  state_t state, state_next;

  logic signed [PW-1:0] win_low, win_low_next;
  logic signed [PW-1:0] win_high, win_high_next;
  logic [DW-1:0]        total, total_next;
  logic [AW-1:0]        q_left, q_left_next;
  logic [AW-1:0]        q_right, q_right_next;
  logic [VW-1:0]        clr_addr, clr_addr_next;
  logic [VW-1:0]        key, key_next;
  logic                 step_enter, step_enter_next;

  logic                 done_next;
  logic [DW-1:0]        distinct_count_next;
  logic [STAT_W-1:0]    status_next;

  logic                 store_we;
  logic [AW-1:0]        store_addr;
  logic [VW-1:0]        store_wdata;
  logic [VW-1:0]        store_rdata;

  logic                 cnt_we;
  logic [VW-1:0]        cnt_addr;
  logic signed [CW-1:0] cnt_wdata;
  logic signed [CW-1:0] cnt_rdata;

  logic signed [PW-1:0] l_s, r_s;
  logic                 win_empty;
  logic signed [CW-1:0] cnt_new;

  assign l_s       = $signed({1'b0, q_left});
  assign r_s       = $signed({1'b0, q_right});
  assign win_empty = win_high < win_low;
  assign busy      = (state != ST_IDLE);

  rdc_ram #(
    .WIDTH (VW),
    .DEPTH (ARRAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .addr  (store_addr),
    .wdata (store_wdata),
    .rdata (store_rdata)
  );

  rdc_ram #(
    .WIDTH (CW),
    .DEPTH (VALUE_COUNT)
  ) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .addr  (cnt_addr),
    .wdata (cnt_wdata),
    .rdata (cnt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      win_low  <= '0;
      win_high <= '1;
      total    <= '0;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      win_low  <= win_low_next;
      win_high <= win_high_next;
      total    <= total_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
    q_left         <= q_left_next;
    q_right        <= q_right_next;
    key            <= key_next;
    step_enter     <= step_enter_next;
    distinct_count <= distinct_count_next;
    status         <= status_next;
  end

  always_comb begin
    state_next          = state;
    win_low_next        = win_low;
    win_high_next       = win_high;
    total_next          = total;
    clr_addr_next       = clr_addr;
    q_left_next         = q_left;
    q_right_next        = q_right;
    key_next            = key;
    step_enter_next     = step_enter;
    done_next           = 1'b0;
    distinct_count_next = distinct_count;
    status_next         = status;

    store_we    = 1'b0;
    store_addr  = AW'(position);
    store_wdata = VW'(value);
    cnt_we      = 1'b0;
    cnt_addr    = key;
    cnt_wdata   = '0;
    cnt_new     = '0;

    case (state)
      ST_CLEAR: begin
        cnt_we        = 1'b1;
        cnt_addr      = clr_addr;
        clr_addr_next = clr_addr + VW'(1);
        if (clr_addr == VW'(VALUE_COUNT - 1)) begin
          clr_addr_next = '0;
          state_next    = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start) begin
          done_next           = 1'b1;
          distinct_count_next = total;
          status_next         = STAT_OK;
          case (command)
            CMD_LOAD: begin
              if (win_empty) begin
                store_we = 1'b1;
              end else begin
                status_next = STAT_REFUSED;
              end
            end
            CMD_QUERY: begin
              q_left_next  = clamp_bound(left);
              q_right_next = clamp_bound(right);
              if (clamp_bound(left) > clamp_bound(right)) begin
                status_next = STAT_BAD_RANGE;
              end else begin
                done_next  = 1'b0;
                state_next = ST_WALK;
              end
            end
            CMD_EMPTY: begin
              distinct_count_next = '0;
              total_next          = '0;
              win_low_next        = '0;
              win_high_next       = '1;
              clr_addr_next       = '0;
              state_next          = ST_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end

      // Pick the next pointer move: right end first, then the left end; with both ends in place, finish the query.
      ST_WALK: begin
        state_next = ST_STORE_WAIT;
        if (win_high < r_s) begin
          win_high_next   = win_high + PW'(1);
          store_addr      = AW'(win_high + PW'(1));
          step_enter_next = 1'b1;
        end else if (win_high > r_s) begin
          win_high_next   = win_high - PW'(1);
          store_addr      = AW'(win_high);
          step_enter_next = 1'b0;
        end else if (win_low < l_s) begin
          win_low_next    = win_low + PW'(1);
          store_addr      = AW'(win_low);
          step_enter_next = 1'b0;
        end else if (win_low > l_s) begin
          win_low_next    = win_low - PW'(1);
          store_addr      = AW'(win_low - PW'(1));
          step_enter_next = 1'b1;
        end else begin
          state_next          = ST_IDLE;
          done_next           = 1'b1;
          distinct_count_next = total;
          status_next         = STAT_OK;
        end
      end

      ST_STORE_WAIT: begin
        cnt_addr   = store_rdata;
        key_next   = store_rdata;
        state_next = ST_COUNT_WAIT;
      end

      // Steps run strictly one after another, so the count read here never
      // races an earlier write to the same entry.
      ST_COUNT_WAIT: begin
        if (step_enter) begin
          cnt_new = cnt_rdata + CW'(1);
          if (cnt_rdata == '0) begin
            total_next = total + DW'(1);
          end
        end else begin
          cnt_new = cnt_rdata - CW'(1);
          if (cnt_new == '0) begin
            total_next = total - DW'(1);
          end
        end
        cnt_we     = 1'b1;
        cnt_addr   = key;
        cnt_wdata  = cnt_new;
        state_next = ST_WALK;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `RDC_ASSERT_NOW(a_cnt_write, cnt_we, state == ST_CLEAR || state == ST_COUNT_WAIT, "count memory written outside sweep or step")
  `RDC_ASSERT_NOW(a_load_empty, store_we, win_high < win_low, "store written while window is non-empty")
  `RDC_ASSERT_NOW(a_total_max, 1'b1, total <= DW'(VALUE_COUNT), "distinct total out of range")
  `RDC_ASSERT_NEXT(a_walk_done, state == ST_WALK && state_next == ST_IDLE, done && status == STAT_OK, "finished query gave no result")

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for the range distinct-count block.
`timescale 1ns / 1ps

module tb;
  import rdc_pkg::*;

  // Command code that the block has no use for; it must answer and change nothing.
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
  localparam longint TIMEOUT_NS = 64'd200_000_000;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [FIELD_W-1:0] pos;
    logic [FIELD_W-1:0] val;
    logic [FIELD_W-1:0] lo;
    logic [FIELD_W-1:0] hi;
  } beat_t;

  typedef struct {
    logic [DW-1:0] tally;
    status_t       code;
  } tally_t;

  class distinct_scoreboard;
    logic [VW-1:0] store [ARRAY_DEPTH];
    int occ [VALUE_COUNT];
    int win_low;
    int win_high;
    int distinct;
    tally_t pending [$];
    int failures, checked, loads, queries, empties, others, widest;

    function new();
      foreach (store[i]) store[i] = '0;
      clear_window();
    endfunction

    function void clear_window();
      foreach (occ[i]) occ[i] = 0;
      distinct = 0;
      win_low = 0;
      win_high = -1;
    endfunction

    function void add_position(int p);
      if (occ[store[p]] == 0) distinct++;
      occ[store[p]]++;
    endfunction

    function void drop_position(int p);
      occ[store[p]]--;
      if (occ[store[p]] == 0) distinct--;
    endfunction

    // Advances the window state by one accepted beat and queues its result.
    function void note_beat(beat_t b);
      tally_t t;
      int lo;
      int hi;
      t.code = STAT_OK;
      case (b.cmd)
        CMD_LOAD: begin
          loads++;
          if (win_high >= win_low) begin
            t.code = STAT_REFUSED;
          end else begin
            store[int'(b.pos) % ARRAY_DEPTH] = VW'(int'(b.val) % VALUE_COUNT);
          end
        end
        CMD_QUERY: begin
          queries++;
          lo = (int'(b.lo) >= ARRAY_DEPTH) ? ARRAY_DEPTH - 1 : int'(b.lo);
          hi = (int'(b.hi) >= ARRAY_DEPTH) ? ARRAY_DEPTH - 1 : int'(b.hi);
          if (lo > hi) begin
            t.code = STAT_BAD_RANGE;
          end else begin
            // The right end moves first, so counts can dip below zero for a while.
            while (win_high < hi) begin
              win_high++;
              add_position(win_high);
            end
            while (win_high > hi) begin
              drop_position(win_high);
              win_high--;
            end
            while (win_low < lo) begin
              drop_position(win_low);
              win_low++;
            end
            while (win_low > lo) begin
              win_low--;
              add_position(win_low);
            end
            if (hi - lo + 1 > widest) widest = hi - lo + 1;
          end
        end
        CMD_EMPTY: begin
          empties++;
          clear_window();
        end
        default: begin
          others++;
        end
      endcase
      t.tally = DW'(distinct);
      pending.insert(pending.size(), t);
    endfunction

    task report(string what);
      $display("tb: mismatch: %s", what);
      failures++;
    endtask

    task check(logic [DW-1:0] got_tally, logic [STAT_W-1:0] got_code);
      tally_t want;
      if (pending.size() == 0) begin
        report($sformatf("result with no beat outstanding (count %0d status %0d)",
                         got_tally, got_code));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got_tally !== want.tally) begin
        report($sformatf("result %0d: distinct_count %0d, expected %0d",
                         checked, got_tally, want.tally));
      end
      if (got_code !== want.code) begin
        report($sformatf("result %0d: status %0d, expected %0d",
                         checked, got_code, want.code));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [CMD_W-1:0]   command = '0;
  logic [FIELD_W-1:0] position = '0;
  logic [FIELD_W-1:0] value = '0;
  logic [FIELD_W-1:0] left = '0;
  logic [FIELD_W-1:0] right = '0;
  logic               busy;
  logic               done;
  logic [DW-1:0]      distinct_count;
  logic [STAT_W-1:0]  status;

  distinct_scoreboard sb;

  // Positions 0 .. filled-1 have all been written, so queries may cover them.
  bit written [ARRAY_DEPTH];
  int filled = 0;
  bit steady = 1'b0;
  int idle_rate = 0;
  int counted = 0;

  range_distinct_count dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command        (command),
    .position       (position),
    .value          (value),
    .left           (left),
    .right          (right),
    .done           (done),
    .distinct_count (distinct_count),
    .status         (status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check(distinct_count, status);
  end

  function automatic int any_field();
    return int'($urandom_range(0, 1023));
  endfunction

  function automatic int pick_value();
    return $urandom_range(0, 1) ? int'($urandom_range(0, 15)) : any_field();
  endfunction

  // Presents one beat, holds it until the block takes it, then maybe idles.
  task automatic issue(logic [CMD_W-1:0] cmd, int pos, int val, int lo, int hi);
    beat_t b;
    b.cmd = cmd;
    b.pos = FIELD_W'(pos);
    b.val = FIELD_W'(val);
    b.lo  = FIELD_W'(lo);
    b.hi  = FIELD_W'(hi);
    if (cmd == CMD_LOAD && sb.win_high < sb.win_low) begin
      written[b.pos] = 1'b1;
      while (filled < ARRAY_DEPTH && written[filled]) filled++;
    end
    start    <= 1'b1;
    command  <= b.cmd;
    position <= b.pos;
    value    <= b.val;
    left     <= b.lo;
    right    <= b.hi;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_beat(b);
    if (cmd != CMD_UNKNOWN) counted++;
    if (!steady && idle_rate != 0 && $urandom_range(0, 3) < idle_rate) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // One beat of a query burst: mostly valid windows over the written prefix.
  task automatic random_step();
    int sel;
    int lo;
    int hi;
    int t;
    sel = $urandom_range(0, 19);
    if (filled == 0 && sel < 16) sel = 16;
    if (sel < 12) begin
      lo = sb.win_low + int'($urandom_range(0, 16)) - 8;
      hi = (sb.win_high < 0 ? 0 : sb.win_high) + int'($urandom_range(0, 16)) - 8;
    end else begin
      lo = $urandom_range(0, filled - 1);
      hi = $urandom_range(0, filled - 1);
    end
    if (sel < 16) begin
      lo = (lo < 0) ? 0 : ((lo > filled - 1) ? filled - 1 : lo);
      hi = (hi < 0) ? 0 : ((hi > filled - 1) ? filled - 1 : hi);
      if (lo > hi) begin
        t = lo;
        lo = hi;
        hi = t;
      end
      issue(CMD_QUERY, any_field(), any_field(), lo, hi);
    end else if (sel < 18) begin
      lo = $urandom_range(1, ARRAY_DEPTH - 1);
      issue(CMD_QUERY, any_field(), any_field(), lo, $urandom_range(0, lo - 1));
    end else if (sel == 18) begin
      issue(CMD_LOAD, any_field(), any_field(), any_field(), any_field());
    end else begin
      issue(CMD_UNKNOWN, any_field(), any_field(), any_field(), any_field());
    end
  endtask

  initial begin
    int sel;
    int p;
    int w;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: bad ranges on an empty window, then a small known store.
    issue(CMD_QUERY, 0, 0, 3, 1);
    issue(CMD_QUERY, 1023, 1023, 1023, 0);
    issue(CMD_LOAD, 0, 1023, 0, 0);
    issue(CMD_LOAD, 1, 0, 1023, 1023);
    issue(CMD_LOAD, 2, 1023, 0, 0);
    issue(CMD_LOAD, 3, 5, 0, 0);
    issue(CMD_LOAD, 4, 0, 0, 0);
    issue(CMD_LOAD, 5, 5, 0, 0);
    issue(CMD_LOAD, 6, 7, 0, 0);
    issue(CMD_LOAD, 7, 7, 0, 0);
    issue(CMD_LOAD, 8, 1023, 0, 0);
    issue(CMD_LOAD, 9, 0, 0, 0);
    issue(CMD_LOAD, 1023, 512, 0, 0);
    issue(CMD_QUERY, 0, 0, 0, 0);
    issue(CMD_QUERY, 0, 0, 2, 9);
    issue(CMD_LOAD, 4, 9, 0, 0);
    issue(CMD_QUERY, 0, 0, 5, 8);
    // The right end drops below the current left end here.
    issue(CMD_QUERY, 0, 0, 0, 2);
    issue(CMD_QUERY, 1023, 1023, 9, 9);
    issue(CMD_UNKNOWN, 1023, 1023, 1023, 1023);
    issue(CMD_QUERY, 0, 0, 5, 4);
    issue(CMD_EMPTY, 1023, 1023, 1023, 1023);
    issue(CMD_QUERY, 0, 0, 0, 9);
    issue(CMD_EMPTY, 0, 0, 0, 0);

    // Random phases: an empty when needed or by chance, a burst of loads, then a burst of queries.
    while (counted < 410) begin
      idle_rate = $urandom_range(0, 3);
      if (sb.win_high >= sb.win_low || $urandom_range(0, 1)) begin
        issue(CMD_EMPTY, any_field(), any_field(), any_field(), any_field());
      end
      repeat ($urandom_range(1, 20)) begin
        sel = $urandom_range(0, 9);
        if (sel < 7 && filled < ARRAY_DEPTH) p = filled;
        else if (sel < 9 && filled > 0) p = $urandom_range(0, filled - 1);
        else p = any_field();
        issue(CMD_LOAD, p, pick_value(), any_field(), any_field());
      end
      repeat ($urandom_range(1, 14)) random_step();
    end

    // Closing stretch without idle: sweep wide windows over the written prefix.
    steady = 1'b1;
    issue(CMD_EMPTY, 0, 0, 0, 0);
    issue(CMD_QUERY, 0, 0, 0, filled - 1);
    issue(CMD_QUERY, 0, 0, filled - 1, filled - 1);
    issue(CMD_QUERY, 0, 0, 0, 0);
    issue(CMD_QUERY, 0, 0, filled / 2, filled - 1);
    issue(CMD_QUERY, 0, 0, 0, filled / 2);
    repeat (20) random_step();
    start <= 1'b0;

    for (w = 0; w < 50000 && sb.pending.size() > 0; w++) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    end

    $display("tb: %0d loads, %0d queries, %0d empties, %0d unknown; %0d results checked",
             sb.loads, sb.queries, sb.empties, sb.others, sb.checked);
    $display("tb: store written to depth %0d, widest window %0d", filled, sb.widest);
    if (sb.failures == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: errors");
    $finish;
  end

endmodule

>>> range_distinct_count.f
+incdir+hw/rtl
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_ram.sv
hw/rtl/range_distinct_count.sv
tb/sv/tb.sv
